>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the range table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, reset included.
`define RRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

// Checked only while out of reset.
`define RRT_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`endif

>>> hw/rtl/rrt_pkg.sv
// Types and constants of the relocation range table.
`default_nettype none

package rrt_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned COUNT_W       = 5;

  localparam logic [1:0] CMD_ADD       = 2'd0;
  localparam logic [1:0] CMD_TRANSLATE = 2'd1;
  localparam logic [1:0] CMD_CLEAR     = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] region_source;
    logic [ADDR_W-1:0] region_length;
    logic [ADDR_W-1:0] region_destination;
    logic [ADDR_W-1:0] query_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  translated_address;
    logic               hit;
    logic [COUNT_W-1:0] entry_count;
  } out_item_t;

  // One table row; range_end is exclusive.
  typedef struct packed {
    logic [ADDR_W-1:0] range_start;
    logic [ADDR_W-1:0] range_end;
    logic [ADDR_W-1:0] range_offset;
  } entry_t;

  typedef struct packed {
    logic              below;   // key < start
    logic              above;   // key >= end
    logic [ADDR_W-1:0] mapped;  // key + offset
  } probe_t;

endpackage

`default_nettype wire

>>> hw/rtl/rrt_probe.sv
// Shared compare unit: tests a key against one table row and forms the mapped address.
`default_nettype none

module rrt_probe (
  input  logic [rrt_pkg::ADDR_W-1:0] key_i,
  input  rrt_pkg::entry_t            entry_i,
  output rrt_pkg::probe_t            probe_o
);

  assign probe_o.below  = key_i < entry_i.range_start;
  assign probe_o.above  = key_i >= entry_i.range_end;
  assign probe_o.mapped = key_i + entry_i.range_offset;

endmodule

`default_nettype wire

>>> hw/rtl/relocation_range_table.sv
// Top level of the relocation range table: sequencer, row memory and result register.
`default_nettype none
`include "assert_macros.svh"

// Sorted table of moved address ranges. One command item is taken at a time; in_ready_o is
// low while it runs. Every row access goes through one memory with a read and a write port,
// registered read data feeding one shared comparator, so each step is a read followed by a
// compare. An add walks down from the row count, moving each row that starts after the new
// one up a slot, and writes the new row where the walk stops or in slot 0; an add on a full
// table is refused. A translate outside the window of all rows misses at once; otherwise a
// binary search runs, at most ceil(log2(n + 1)) probes over n rows. Clear and the unused
// command go straight to the result. The result sits in an output register, so the next item
// is taken while it waits. Rows are not cleared at reset; only rows below the count are ever
// read.
module relocation_range_table #(
  parameter int unsigned TABLE_DEPTH = rrt_pkg::DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rrt_pkg::in_item_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rrt_pkg::out_item_t out_o
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW = rrt_pkg::ADDR_W;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_ADD_RD   = 6'b000010,
    S_ADD_CMP  = 6'b000100,
    S_SRCH_RD  = 6'b001000,
    S_SRCH_CMP = 6'b010000,
    S_DONE     = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  rrt_pkg::in_item_t  req_q, req_d;
  rrt_pkg::entry_t    new_q, new_d;
  rrt_pkg::out_item_t res_q, res_d;
  rrt_pkg::out_item_t out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [IW-1:0]      mid_q, mid_d;
  logic [CW-1:0]      left_q, left_d;
  logic [CW-1:0]      right_q, right_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      low_q, low_d;
  logic [AW-1:0]      high_q, high_d;

  rrt_pkg::entry_t    mem [TABLE_DEPTH];
  rrt_pkg::entry_t    rdata_q;
  logic               mem_we, mem_re;
  logic [IW-1:0]      mem_waddr, mem_raddr;
  rrt_pkg::entry_t    mem_wdata;

  logic [CW:0]        mid_sum;
  logic [IW-1:0]      mid_w;
  logic [AW-1:0]      probe_key;
  rrt_pkg::probe_t    probe;
  logic [CW-1:0]      add_count;
  logic [1:0]         add_status;
  logic [AW-1:0]      add_low, add_high;
  logic               win_hit;

  assign probe_key = (state_q == S_ADD_CMP) ? req_q.region_source : req_q.query_address;

  rrt_probe u_probe (
    .key_i   (probe_key),
    .entry_i (rdata_q),
    .probe_o (probe)
  );

  assign mid_sum = {1'b0, left_q} + {1'b0, right_q};
  assign mid_w   = mid_sum[IW:1];

  // Bookkeeping applied on the cycle the new row is written.
  assign add_count  = count_q + CW'(1);
  assign add_status = (add_count == CW'(TABLE_DEPTH)) ? rrt_pkg::ST_FULL : rrt_pkg::ST_DONE;
  always_comb begin
    if (count_q == '0) begin
      add_low  = new_q.range_start;
      add_high = new_q.range_end;
    end else begin
      add_low  = (new_q.range_start < low_q) ? new_q.range_start : low_q;
      add_high = (new_q.range_end > high_q) ? new_q.range_end : high_q;
    end
  end

  assign win_hit = (in_i.query_address >= low_q) && (in_i.query_address < high_q);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    new_d       = new_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    idx_d       = idx_q;
    mid_d       = mid_q;
    left_d      = left_q;
    right_d     = right_q;
    count_d     = count_q;
    low_d       = low_q;
    high_d      = high_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = new_q;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d              = in_i;
          new_d.range_start  = in_i.region_source;
          new_d.range_end    = in_i.region_source + in_i.region_length;
          new_d.range_offset = in_i.region_destination - in_i.region_source;
          res_d              = '0;
          state_d            = S_DONE;
          case (in_i.command)
            rrt_pkg::CMD_ADD: begin
              if (count_q >= CW'(TABLE_DEPTH)) begin
                res_d.status = rrt_pkg::ST_REFUSED;
              end else begin
                idx_d   = count_q[IW-1:0];
                state_d = S_ADD_RD;
              end
            end
            rrt_pkg::CMD_TRANSLATE: begin
              res_d.translated_address = in_i.query_address;
              left_d                   = '0;
              right_d                  = count_q;
              if (win_hit) begin
                state_d = S_SRCH_RD;
              end
            end
            rrt_pkg::CMD_CLEAR: begin
              count_d = '0;
              low_d   = '0;
              high_d  = '0;
            end
            default: ;
          endcase
        end
      end
      S_ADD_RD: begin
        if (idx_q == '0) begin
          mem_we       = 1'b1;
          count_d      = add_count;
          low_d        = add_low;
          high_d       = add_high;
          res_d.status = add_status;
          state_d      = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_q - IW'(1);
          state_d   = S_ADD_CMP;
        end
      end
      S_ADD_CMP: begin
        mem_we = 1'b1;
        if (probe.below) begin
          // row below starts after the new one: move it up a slot
          mem_wdata = rdata_q;
          idx_d     = idx_q - IW'(1);
          state_d   = S_ADD_RD;
        end else begin
          count_d      = add_count;
          low_d        = add_low;
          high_d       = add_high;
          res_d.status = add_status;
          state_d      = S_DONE;
        end
      end
      S_SRCH_RD: begin
        if (left_q < right_q) begin
          mem_re    = 1'b1;
          mem_raddr = mid_w;
          mid_d     = mid_w;
          state_d   = S_SRCH_CMP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SRCH_CMP: begin
        if (probe.below) begin
          right_d = CW'(mid_q);
          state_d = S_SRCH_RD;
        end else if (probe.above) begin
          left_d  = CW'(mid_q) + CW'(1);
          state_d = S_SRCH_RD;
        end else begin
          res_d.translated_address = probe.mapped;
          res_d.hit                = 1'b1;
          state_d                  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d             = res_q;
          out_d.entry_count = rrt_pkg::COUNT_W'(count_q);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      low_q       <= '0;
      high_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      low_q       <= low_d;
      high_q      <= high_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    new_q   <= new_d;
    res_q   <= res_d;
    out_q   <= out_d;
    idx_q   <= idx_d;
    mid_q   <= mid_d;
    left_q  <= left_d;
    right_q <= right_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `RRT_ASSERT_RUN(a_count_bound, count_q <= CW'(TABLE_DEPTH), "row count above table depth")
  `RRT_ASSERT_RUN(a_srch_bounds,
    (state_q == S_SRCH_RD || state_q == S_SRCH_CMP) |-> (left_q <= right_q && right_q <= count_q),
    "search bounds out of order")
  `RRT_ASSERT_RUN(a_add_room,
    (state_q == S_ADD_RD || state_q == S_ADD_CMP) |-> (count_q < CW'(TABLE_DEPTH) && CW'(idx_q) <= count_q),
    "insert running without room")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench of the relocation range table: directed rows, then random sequences.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rrt_pkg::*;

  localparam int          CLK_PERIOD = 20;
  localparam int          DEPTH      = DEPTH_DEFAULT;
  localparam int          STALL_MAX  = 4000;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;

  typedef struct {
    in_item_t  item;
    bit        known;
    out_item_t want;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_i        = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_o;

  // Predictor copy of the table
  logic [31:0] tbl_start [DEPTH];
  logic [31:0] tbl_end [DEPTH];
  logic [31:0] tbl_offset [DEPTH];
  int          tbl_count = 0;
  logic [31:0] win_low   = '0;
  logic [31:0] win_high  = '0;

  out_item_t   remap_q[$];
  out_item_t   want_res;
  out_item_t   predicted;
  dir_row_t    dir_rows[$];
  int          mismatch_count = 0;
  int          stall_cycles   = 0;
  int unsigned send_idle_pct  = 6;
  int unsigned recv_idle_pct  = 77;

  relocation_range_table #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic out_item_t remap_step(input in_item_t it);
    out_item_t   r;
    int          pos;
    int          lo;
    int          hi;
    int          mid;
    bit          found;
    logic [31:0] end_addr;
    r = '0;
    case (it.command)
      CMD_ADD: begin
        if (tbl_count >= DEPTH) begin
          r.status = ST_REFUSED;
        end else begin
          end_addr = it.region_source + it.region_length;
          pos = 0;
          // equal starts: new region lands after the held ones
          while (pos < tbl_count && tbl_start[pos] <= it.region_source) pos++;
          for (int i = tbl_count; i > pos; i--) begin
            tbl_start[i]  = tbl_start[i-1];
            tbl_end[i]    = tbl_end[i-1];
            tbl_offset[i] = tbl_offset[i-1];
          end
          tbl_start[pos]  = it.region_source;
          tbl_end[pos]    = end_addr;
          tbl_offset[pos] = it.region_destination - it.region_source;
          if (tbl_count == 0) begin
            win_low  = it.region_source;
            win_high = end_addr;
          end else begin
            if (it.region_source < win_low) win_low = it.region_source;
            if (end_addr > win_high) win_high = end_addr;
          end
          tbl_count++;
          r.status = (tbl_count == DEPTH) ? ST_FULL : ST_DONE;
        end
      end
      CMD_TRANSLATE: begin
        r.translated_address = it.query_address;
        if (it.query_address >= win_low && it.query_address < win_high) begin
          lo = 0;
          hi = tbl_count;
          found = 1'b0;
          while (lo < hi && !found) begin
            mid = (lo + hi) / 2;
            if (it.query_address < tbl_start[mid]) begin
              hi = mid;
            end else if (it.query_address >= tbl_end[mid]) begin
              lo = mid + 1;
            end else begin
              found = 1'b1;
              r.hit = 1'b1;
              r.translated_address = it.query_address + tbl_offset[mid];
            end
          end
        end
      end
      CMD_CLEAR: begin
        tbl_count = 0;
        win_low   = '0;
        win_high  = '0;
      end
      default: ;
    endcase
    r.entry_count = tbl_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic in_item_t cmd_item(input logic [1:0] cmd, input logic [31:0] src,
                                        input logic [31:0] len, input logic [31:0] dst,
                                        input logic [31:0] qa);
    in_item_t it;
    it.command            = cmd;
    it.region_source      = src;
    it.region_length      = len;
    it.region_destination = dst;
    it.query_address      = qa;
    return it;
  endfunction

  function automatic dir_row_t row_free(input in_item_t it);
    dir_row_t row;
    row.item  = it;
    row.known = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic dir_row_t row_known(input in_item_t it, input logic [1:0] st,
                                         input logic [31:0] xl, input logic h,
                                         input logic [4:0] cnt);
    dir_row_t row;
    row.item  = it;
    row.known = 1'b1;
    row.want.status             = st;
    row.want.translated_address = xl;
    row.want.hit                = h;
    row.want.entry_count        = cnt;
    return row;
  endfunction

  task automatic report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) report_error($sformatf("%s: expected %h, got %h", name, want, got));
  endtask

  // Holds valid until the item is taken; leaves valid high after the accepting edge.
  task automatic drive_item(input in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (remap_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int n_items);
    in_item_t    it;
    int          pick;
    int          idx;
    logic [31:0] span;
    for (int k = 0; k < n_items; k++) begin
      it.command            = CMD_TRANSLATE;
      it.region_source      = $urandom();
      it.region_length      = $urandom();
      it.region_destination = $urandom();
      it.query_address      = $urandom();
      pick = $urandom_range(99);
      if (pick < 3) begin
        it.command = 2'($urandom_range(3));
      end else if (pick < 6 || (tbl_count >= DEPTH && pick < 25)) begin
        it.command = CMD_CLEAR;
      end else if (pick < 50) begin
        it.command = CMD_ADD;
        case ($urandom_range(7))
          0: ;
          1: begin
            it.region_source = $urandom() & 32'hFFFF_F000;
            it.region_length = $urandom_range(1, 4096);
          end
          2: it.region_length = '0;
          3: begin
            // end can wrap past the top of the address space
            it.region_source = 32'hFFFF_F000 | ($urandom() & 32'hFFF);
            it.region_length = $urandom_range(1, 32'h2000);
          end
          4: if (tbl_count > 0) it.region_source = tbl_start[$urandom_range(tbl_count - 1)];
          default: begin
            it.region_source = $urandom_range(32'hFFFF) & ~32'hF;
            it.region_length = $urandom_range(1, 32'h800);
          end
        endcase
      end else if (tbl_count > 0 && $urandom_range(3) != 0) begin
        idx  = $urandom_range(tbl_count - 1);
        span = tbl_end[idx] - tbl_start[idx];
        case ($urandom_range(4))
          0: it.query_address = tbl_start[idx];
          1: it.query_address = tbl_end[idx] - 1;
          2: it.query_address = tbl_end[idx];
          3: it.query_address = tbl_start[idx] - 1;
          default: it.query_address = tbl_start[idx] + ((span == 0) ? 0 : $urandom_range(span - 1));
        endcase
      end else if ($urandom_range(1) == 1) begin
        it.query_address = $urandom_range(32'h1FFFF);
      end
      if ($urandom_range(99) == 0) wait_drained();
      drive_item(it);
      remap_q.push_back(remap_step(it));
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (remap_q.size() == 0) begin
        report_error("result item with no expectation pending");
      end else begin
        want_res = remap_q.pop_front();
        check_field("status", want_res.status, out_o.status);
        check_field("translated_address", want_res.translated_address,
                    out_o.translated_address);
        check_field("hit", want_res.hit, out_o.hit);
        check_field("entry_count", want_res.entry_count, out_o.entry_count);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    dir_rows.push_back(row_known(cmd_item(CMD_TRANSLATE, 0, 0, 0, 32'h0),
                                 ST_DONE, 32'h0, 1'b0, 5'd0));
    dir_rows.push_back(row_known(cmd_item(CMD_TRANSLATE, 0, 0, 0, 32'hFFFF_FFFF),
                                 ST_DONE, 32'hFFFF_FFFF, 1'b0, 5'd0));
    dir_rows.push_back(row_known(cmd_item(CMD_UNUSED, '1, '1, '1, '1),
                                 ST_DONE, 32'h0, 1'b0, 5'd0));
    dir_rows.push_back(row_known(cmd_item(CMD_CLEAR, '1, '1, '1, '1),
                                 ST_DONE, 32'h0, 1'b0, 5'd0));
    dir_rows.push_back(row_known(cmd_item(CMD_ADD, 32'h1000, 32'h100, 32'h8000, 0),
                                 ST_DONE, 32'h0, 1'b0, 5'd1));
    dir_rows.push_back(row_known(cmd_item(CMD_TRANSLATE, 0, 0, 0, 32'h1000),
                                 ST_DONE, 32'h8000, 1'b1, 5'd1));
    // end is exclusive
    dir_rows.push_back(row_known(cmd_item(CMD_TRANSLATE, 0, 0, 0, 32'h1100),
                                 ST_DONE, 32'h1100, 1'b0, 5'd1));
    dir_rows.push_back(row_free(cmd_item(CMD_ADD, 32'hFFFF_FF00, 32'h100, 32'h40, 0)));
    dir_rows.push_back(row_free(cmd_item(CMD_TRANSLATE, 0, 0, 0, 32'hFFFF_FF80)));
    dir_rows.push_back(row_free(cmd_item(CMD_ADD, 32'h1000, 32'h200, 32'h0, 0)));
    dir_rows.push_back(row_free(cmd_item(CMD_TRANSLATE, 0, 0, 0, 32'h10FF)));
    dir_rows.push_back(row_free(cmd_item(CMD_ADD, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0)));
    dir_rows.push_back(row_free(cmd_item(CMD_ADD, 32'h5000, 32'h0, 32'h123, 0)));
    dir_rows.push_back(row_free(cmd_item(CMD_TRANSLATE, 0, 0, 0, 32'h5000)));
    for (int k = 0; k < 10; k++) begin
      dir_rows.push_back(row_free(cmd_item(CMD_ADD, 32'h2_0000 + k * 32'h1000, 32'h800,
                                           32'h9000_0000 + k, 0)));
    end
    dir_rows.push_back(row_known(cmd_item(CMD_ADD, 32'h2_A000, 32'h800, 32'h9000_000A, 0),
                                 ST_FULL, 32'h0, 1'b0, 5'd16));
    dir_rows.push_back(row_known(cmd_item(CMD_ADD, '1, '1, '1, 0),
                                 ST_REFUSED, 32'h0, 1'b0, 5'd16));
    dir_rows.push_back(row_free(cmd_item(CMD_TRANSLATE, 0, 0, 0, 32'h2_4400)));
    dir_rows.push_back(row_known(cmd_item(CMD_CLEAR, 0, 0, 0, 0),
                                 ST_DONE, 32'h0, 1'b0, 5'd0));
    dir_rows.push_back(row_known(cmd_item(CMD_TRANSLATE, 0, 0, 0, 32'h2_4400),
                                 ST_DONE, 32'h2_4400, 1'b0, 5'd0));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      drive_item(dir_rows[i].item);
      predicted = remap_step(dir_rows[i].item);
      remap_q.push_back(dir_rows[i].known ? dir_rows[i].want : predicted);
    end
    run_random(474);

    wait_drained();
    send_idle_pct = 77;
    recv_idle_pct = 6;
    run_random(474);

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(474);

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
